// ===== src/dynamic_manhattan_farthest_point_core_defines.svh =====
// ----------------------------------------------------------------------------
// dynamic_manhattan_farthest_point_core_defines
// assertion macros for the port-level checker dmfp_chk
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_MANHATTAN_FARTHEST_POINT_CORE_DEFINES_SVH
`define DYNAMIC_MANHATTAN_FARTHEST_POINT_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define DMFP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DMFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dmfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmfp_pkg
// shared widths, codes and types of the farthest point core
// ----------------------------------------------------------------------------
package dmfp_pkg;

    // item field widths
    localparam int OP_W     = 2;
    localparam int COORD_W  = 32;
    localparam int NUM_W    = 11;
    localparam int STATUS_W = 2;
    localparam int DIST_W   = 33;

    // parameter defaults
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_COORD_BITS = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // control from the sequencer to the distance unit
    typedef struct packed {
        logic clear;
        logic valid;
        logic alive;
    } t_dist_ctl;

    // status from the distance unit back to the sequencer
    typedef struct packed {
        logic pend;
        logic found;
    } t_dist_sts;

endpackage

// ===== src/dmfp_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmfp_dist
// shared distance unit: abs differences, then sum and running maximum
// ----------------------------------------------------------------------------
module dmfp_dist #(
    parameter int COORD_BITS = dmfp_pkg::DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dmfp_pkg::t_dist_ctl          i_ctl,
    input  logic signed [COORD_BITS-1:0] i_pt_x,
    input  logic signed [COORD_BITS-1:0] i_pt_y,
    input  logic signed [COORD_BITS-1:0] i_qx,
    input  logic signed [COORD_BITS-1:0] i_qy,
    output logic        [COORD_BITS:0]   o_best,
    output dmfp_pkg::t_dist_sts          o_sts
);
    import dmfp_pkg::*;

    logic signed [COORD_BITS:0] w_px;
    logic signed [COORD_BITS:0] w_py;
    logic signed [COORD_BITS:0] w_qx;
    logic signed [COORD_BITS:0] w_qy;
    logic        [COORD_BITS:0] w_dx;
    logic        [COORD_BITS:0] w_dy;
    logic        [COORD_BITS:0] w_sum;

    logic [COORD_BITS:0] r_dx;
    logic [COORD_BITS:0] r_dy;
    logic                r_v2;
    logic [COORD_BITS:0] r_best;
    logic                r_found;

    // sign extend so differences cannot overflow
    assign w_px = {i_pt_x[COORD_BITS-1], i_pt_x};
    assign w_py = {i_pt_y[COORD_BITS-1], i_pt_y};
    assign w_qx = {i_qx[COORD_BITS-1], i_qx};
    assign w_qy = {i_qy[COORD_BITS-1], i_qy};

    // absolute differences, larger minus smaller
    assign w_dx = (i_pt_x >= i_qx) ? $unsigned(w_px - w_qx) : $unsigned(w_qx - w_px);
    assign w_dy = (i_pt_y >= i_qy) ? $unsigned(w_py - w_qy) : $unsigned(w_qy - w_py);

    // sum fits: at most 2^(COORD_BITS+1) - 2
    assign w_sum = r_dx + r_dy;

    // stage one: abs differences of a live entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= i_ctl.valid && i_ctl.alive && !i_ctl.clear;
        end
        r_dx <= w_dx;
        r_dy <= w_dy;
    end

    // stage two: running maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_best  <= '0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
            r_best  <= '0;
        end else if (r_v2) begin
            r_found <= 1'b1;
            if (!r_found || (w_sum > r_best)) begin
                r_best <= w_sum;
            end
        end
    end

    assign o_best      = r_best;
    assign o_sts.pend  = r_v2;
    assign o_sts.found = r_found;

endmodule

// ===== src/dynamic_manhattan_farthest_point_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_manhattan_farthest_point_core
// dynamic point store answering farthest Manhattan distance queries
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows on the
// o_ ports for exactly one cycle with o_done high and cannot be held off.
// Insert, a remove with a zero or out-of-range number, a query on an empty
// store and the unused code answer in the cycle after acceptance and keep busy
// low. A remove with an in-range number answers after one store read, then
// the check and clear of the live flag. A query reads the store one entry
// per cycle from its single read port, and each entry goes through one
// shared distance and compare unit; the read, difference and compare stages
// then drain before the result register loads. Busy is high for the whole
// scan.
// ----------------------------------------------------------------------------
module dynamic_manhattan_farthest_point_core #(
    parameter int MAX_POINTS = dmfp_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = dmfp_pkg::DEF_COORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dmfp_pkg::OP_W-1:0]       i_operation,
    input  logic signed [dmfp_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [dmfp_pkg::COORD_W-1:0] i_coord_y,
    input  logic [dmfp_pkg::NUM_W-1:0]      i_point_number,
    output logic                            o_done,
    output logic [dmfp_pkg::STATUS_W-1:0]   o_status,
    output logic [dmfp_pkg::DIST_W-1:0]     o_distance,
    output logic [dmfp_pkg::NUM_W-1:0]      o_assigned_number
);
    import dmfp_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int CMPW = (CW > NUM_W) ? CW : NUM_W;

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REMOVE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_DRAIN  = 2'd3;

    // point stores
    logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];
    logic                         mem_alive [MAX_POINTS];

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic          r_v1;
    logic [AW-1:0] r_rm_addr;

    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] r_qy;
    logic signed [COORD_BITS-1:0] r_rd_x;
    logic signed [COORD_BITS-1:0] r_rd_y;
    logic                         r_rd_alive;

    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [DIST_W-1:0]   r_distance;
    logic [NUM_W-1:0]    r_assigned;

    logic                         w_accept;
    logic                         w_full;
    logic                         w_rm_ok;
    logic [NUM_W-1:0]             w_num_m1;
    logic [AW-1:0]                w_rm_addr;
    logic [AW-1:0]                w_rd_addr;
    logic                         w_last;
    logic                         w_xy_we;
    logic                         w_al_we;
    logic [AW-1:0]                w_al_addr;
    logic                         w_al_data;
    logic signed [COORD_BITS-1:0] w_in_x;
    logic signed [COORD_BITS-1:0] w_in_y;
    logic [COORD_BITS:0]          w_best;
    t_dist_ctl                    w_ctl;
    t_dist_sts                    w_sts;

    // item decode
    assign w_accept  = start && !busy;
    assign w_full    = (r_count == CW'(MAX_POINTS));
    assign w_num_m1  = i_point_number - NUM_W'(1);
    assign w_rm_addr = AW'(w_num_m1);
    assign w_rm_ok   = (i_point_number != '0) &&
                       (CMPW'(i_point_number) <= CMPW'(r_count));
    assign w_last    = (r_idx == AW'(r_count - CW'(1)));
    assign w_in_x    = i_coord_x[COORD_BITS-1:0];
    assign w_in_y    = i_coord_y[COORD_BITS-1:0];

    // store write and read control
    assign w_xy_we   = w_accept && (i_operation == OP_INSERT) && !w_full;
    assign w_al_we   = w_xy_we || ((r_state == S_REMOVE) && r_rd_alive);
    assign w_al_addr = (r_state == S_REMOVE) ? r_rm_addr : r_count[AW-1:0];
    assign w_al_data = (r_state != S_REMOVE);
    assign w_rd_addr = (r_state == S_SCAN) ? r_idx : w_rm_addr;

    // coordinate stores
    always_ff @(posedge i_clk) begin
        if (w_xy_we) begin
            mem_x[r_count[AW-1:0]] <= w_in_x;
            mem_y[r_count[AW-1:0]] <= w_in_y;
        end
        r_rd_x <= mem_x[w_rd_addr];
        r_rd_y <= mem_y[w_rd_addr];
    end

    // live flags, valid below the fill count only
    always_ff @(posedge i_clk) begin
        if (w_al_we) begin
            mem_alive[w_al_addr] <= w_al_data;
        end
        r_rd_alive <= mem_alive[w_rd_addr];
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (w_accept) begin
                    if ((i_operation == OP_INSERT) && !w_full) begin
                        n_count = r_count + CW'(1);
                    end else if ((i_operation == OP_REMOVE) && w_rm_ok) begin
                        n_state = S_REMOVE;
                    end else if ((i_operation == OP_QUERY) && (r_count != '0)) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_REMOVE: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                n_idx = r_idx + AW'(1);
                if (w_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !w_sts.pend) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_v1    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_v1    <= (r_state == S_SCAN);
        end
        r_idx <= n_idx;
    end

    // query point and remove address
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_qx      <= w_in_x;
            r_qy      <= w_in_y;
            r_rm_addr <= w_rm_addr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            priority if (r_state == S_REMOVE) begin
                r_done <= 1'b1;
            end else if ((r_state == S_DRAIN) && !r_v1 && !w_sts.pend) begin
                r_done <= 1'b1;
            end else if (w_accept && (n_state == S_IDLE)) begin
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end

        priority if (r_state == S_REMOVE) begin
            r_status   <= r_rd_alive ? ST_OK : ST_BAD_INDEX;
            r_distance <= '0;
            r_assigned <= '0;
        end else if (r_state == S_DRAIN) begin
            r_status   <= w_sts.found ? ST_OK : ST_EMPTY;
            r_distance <= w_sts.found ? DIST_W'(w_best) : '0;
            r_assigned <= '0;
        end else if (w_accept) begin
            r_distance <= '0;
            unique case (i_operation)
                OP_INSERT: begin
                    r_status   <= w_full ? ST_FULL : ST_OK;
                    r_assigned <= w_full ? '0 : NUM_W'(r_count + CW'(1));
                end
                OP_REMOVE: begin
                    r_status   <= ST_BAD_INDEX;
                    r_assigned <= '0;
                end
                OP_QUERY: begin
                    r_status   <= ST_EMPTY;
                    r_assigned <= '0;
                end
                OP_NONE: begin
                    r_status   <= ST_OK;
                    r_assigned <= '0;
                end
                default: begin
                    r_status   <= ST_OK;
                    r_assigned <= '0;
                end
            endcase
        end
    end

    // shared distance unit
    assign w_ctl.clear = w_accept;
    assign w_ctl.valid = r_v1;
    assign w_ctl.alive = r_rd_alive;

    dmfp_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_pt_x  (r_rd_x),
        .i_pt_y  (r_rd_y),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_best  (w_best),
        .o_sts   (w_sts)
    );

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_distance        = r_distance;
    assign o_assigned_number = r_assigned;

endmodule

// ===== src/dmfp_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmfp_chk
// port-level checks on the farthest point core, bound to the top level
// ----------------------------------------------------------------------------
`include "dynamic_manhattan_farthest_point_core_defines.svh"

module dmfp_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic [dmfp_pkg::STATUS_W-1:0] o_status,
    input logic [dmfp_pkg::DIST_W-1:0]   o_distance,
    input logic [dmfp_pkg::NUM_W-1:0]    o_assigned_number
);
    import dmfp_pkg::*;

    // a result never shows while work is still running
    `DMFP_ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, o_done, !busy, "result while busy")

    // an accepted item either answers next cycle or keeps the core busy
    `DMFP_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, o_done || busy, "item dropped")

    // busy ends only with a result
    `DMFP_ASSERT_SAME(a_busy_end_done, i_clk, i_rst_n, $fell(busy), o_done, "busy ended without result")

    // failed items carry no distance and no number
    `DMFP_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_done && (o_status != ST_OK), (o_distance == '0) && (o_assigned_number == '0), "nonzero payload on failure")

endmodule

bind dynamic_manhattan_farthest_point_core dmfp_chk u_dmfp_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_status          (o_status),
    .o_distance        (o_distance),
    .o_assigned_number (o_assigned_number)
);

// ===== tb/dynamic_manhattan_farthest_point_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_manhattan_farthest_point_core_checker
// keeps its own copy of the point store, works out the answer to every
// accepted item and compares each o_done result with the oldest open answer
// ----------------------------------------------------------------------------
module dynamic_manhattan_farthest_point_core_checker #(
    parameter int MAX_POINTS = dmfp_pkg::DEF_MAX_POINTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [dmfp_pkg::OP_W-1:0]           i_operation,
    input  logic signed [dmfp_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [dmfp_pkg::COORD_W-1:0] i_coord_y,
    input  logic [dmfp_pkg::NUM_W-1:0]          i_point_number,
    input  logic                                o_done,
    input  logic [dmfp_pkg::STATUS_W-1:0]       o_status,
    input  logic [dmfp_pkg::DIST_W-1:0]         o_distance,
    input  logic [dmfp_pkg::NUM_W-1:0]          o_assigned_number,
    output int                                  o_fail_count,
    output int                                  o_open_answers
);
    import dmfp_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DIST_W-1:0]   distance;
        logic [NUM_W-1:0]    number;
    } t_point_answer;

    // shadow copy of the point store
    logic signed [COORD_W-1:0] shadow_x [MAX_POINTS];
    logic signed [COORD_W-1:0] shadow_y [MAX_POINTS];
    bit                        shadow_live [MAX_POINTS];
    int                        stored_points = 0;

    t_point_answer open_answers [$];
    int            mismatches = 0;
    int            open_count = 0;

    assign o_fail_count   = mismatches;
    assign o_open_answers = open_count;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // apply one item to the shadow store and return the answer it must give
    function automatic t_point_answer apply_point_command(
        input logic [OP_W-1:0]           op,
        input logic signed [COORD_W-1:0] qx,
        input logic signed [COORD_W-1:0] qy,
        input logic [NUM_W-1:0]          num
    );
        t_point_answer ans;
        longint        best;
        longint        dx;
        longint        dy;
        bit            found;
        ans   = '0;
        best  = 0;
        found = 1'b0;
        case (op)
            OP_INSERT: begin
                if (stored_points >= MAX_POINTS) begin
                    ans.status = ST_FULL;
                end else begin
                    shadow_x[stored_points]    = qx;
                    shadow_y[stored_points]    = qy;
                    shadow_live[stored_points] = 1'b1;
                    stored_points++;
                    ans.number = NUM_W'(stored_points);
                end
            end
            OP_REMOVE: begin
                if (num == '0 || int'(num) > stored_points) begin
                    ans.status = ST_BAD_INDEX;
                end else if (!shadow_live[int'(num) - 1]) begin
                    ans.status = ST_BAD_INDEX;
                end else begin
                    shadow_live[int'(num) - 1] = 1'b0;
                end
            end
            OP_QUERY: begin
                // scan every slot ever written, dead ones skipped
                for (int i = 0; i < stored_points; i++) begin
                    if (shadow_live[i]) begin
                        dx = longint'(shadow_x[i]) - longint'(qx);
                        dy = longint'(shadow_y[i]) - longint'(qy);
                        if (dx < 0) dx = -dx;
                        if (dy < 0) dy = -dy;
                        if (!found || dx + dy > best) best = dx + dy;
                        found = 1'b1;
                    end
                end
                if (found) ans.distance = best[DIST_W-1:0];
                else ans.status = ST_EMPTY;
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    // results first, then the item taken at the same edge
    always @(posedge i_clk) begin : watch_channels
        t_point_answer want;
        t_point_answer fresh;
        if (i_rst_n) begin
            if (o_done) begin
                if (open_answers.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = open_answers.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  o_status, want.status));
                    if (o_distance !== want.distance)
                        report_mismatch($sformatf("distance got %0d want %0d",
                                                  o_distance, want.distance));
                    if (o_assigned_number !== want.number)
                        report_mismatch($sformatf("number got %0d want %0d",
                                                  o_assigned_number, want.number));
                end
            end
            if (start && !busy) begin
                fresh = apply_point_command(i_operation, i_coord_x,
                                            i_coord_y, i_point_number);
                open_answers = {open_answers, fresh};
            end
            open_count = open_answers.size();
        end
    end

endmodule

// ===== tb/dynamic_manhattan_farthest_point_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_manhattan_farthest_point_core_tb
// drives insert, remove and query items into the farthest point core, with a
// directed opening, random traffic under several idle settings and closing
// items at the coordinate extremes; the checker beside the block judges every
// result
// ----------------------------------------------------------------------------
module dynamic_manhattan_farthest_point_core_tb;
    import dmfp_pkg::*;

    localparam int                        MAX_POINTS = DEF_MAX_POINTS;
    localparam logic signed [COORD_W-1:0] COORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN  = 32'sh8000_0000;
    localparam int                        RANDOM_ITEMS = 420;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [OP_W-1:0]             i_operation;
    logic signed [COORD_W-1:0]   i_coord_x;
    logic signed [COORD_W-1:0]   i_coord_y;
    logic [NUM_W-1:0]            i_point_number;
    logic                        o_done;
    logic [STATUS_W-1:0]         o_status;
    logic [DIST_W-1:0]           o_distance;
    logic [NUM_W-1:0]            o_assigned_number;
    int                          fail_count;
    int                          open_answers;

    int idle_pct      = 0;
    int issued_points = 0;

    dynamic_manhattan_farthest_point_core #(
        .MAX_POINTS(MAX_POINTS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_point_number   (i_point_number),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_distance       (o_distance),
        .o_assigned_number(o_assigned_number)
    );

    dynamic_manhattan_farthest_point_core_checker #(
        .MAX_POINTS(MAX_POINTS)
    ) checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_point_number   (i_point_number),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_distance       (o_distance),
        .o_assigned_number(o_assigned_number),
        .o_fail_count     (fail_count),
        .o_open_answers   (open_answers)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // idle gap, then present one item and hold it until taken
    task automatic send_command(
        input logic [OP_W-1:0]           op,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic [NUM_W-1:0]          num
    );
        int gap;
        gap = 0;
        while (gap < 64 && $urandom_range(99) < idle_pct) gap++;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_operation    <= op;
        i_coord_x      <= x;
        i_coord_y      <= y;
        i_point_number <= num;
        do @(posedge i_clk); while (busy);
        if (op == OP_INSERT && issued_points < MAX_POINTS) issued_points++;
    endtask

    // mix of extremes, small values and full-range values
    function automatic logic signed [COORD_W-1:0] pick_coord();
        int r;
        r = $urandom_range(7);
        case (r)
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2, 3:    return COORD_W'($urandom_range(200)) - 32'sd100;
            default: return $urandom;
        endcase
    endfunction

    // mostly numbers of points already inserted, sometimes bad ones
    function automatic logic [NUM_W-1:0] pick_point_number();
        int r;
        r = $urandom_range(99);
        if (r < 65 && issued_points > 0) return NUM_W'($urandom_range(issued_points, 1));
        if (r < 75) return '0;
        if (r < 85) return NUM_W'($urandom_range(2047, issued_points + 1));
        return NUM_W'($urandom_range(2047));
    endfunction

    task automatic send_random_item();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            send_command(OP_INSERT, pick_coord(), pick_coord(), NUM_W'($urandom_range(2047)));
        else if (r < 60)
            send_command(OP_REMOVE, $urandom, $urandom, pick_point_number());
        else if (r < 95)
            send_command(OP_QUERY, pick_coord(), pick_coord(), NUM_W'($urandom_range(2047)));
        else
            send_command(OP_NONE, $urandom, $urandom, NUM_W'($urandom_range(2047)));
    endtask

    // stimulus and verdict
    initial begin
        int waited;
        start          = 1'b0;
        i_rst_n        = 1'b0;
        i_operation    = OP_NONE;
        i_coord_x      = '0;
        i_coord_y      = '0;
        i_point_number = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, extremes, dead and out-of-range numbers
        send_command(OP_QUERY,  32'sd5, -32'sd5, 11'd0);
        send_command(OP_REMOVE, '0, '0, 11'd0);
        send_command(OP_REMOVE, '0, '0, 11'd1);
        send_command(OP_NONE,   32'sd123, -32'sd7, 11'd9);
        send_command(OP_INSERT, COORD_MAX, COORD_MAX, 11'd0);
        send_command(OP_INSERT, COORD_MIN, COORD_MIN, 11'd2047);
        send_command(OP_QUERY,  '0, '0, 11'd0);
        send_command(OP_QUERY,  COORD_MAX, COORD_MAX, 11'd0);
        send_command(OP_QUERY,  COORD_MIN, COORD_MAX, 11'd0);
        send_command(OP_REMOVE, COORD_MIN, COORD_MAX, 11'd1);
        send_command(OP_REMOVE, '0, '0, 11'd1);
        send_command(OP_QUERY,  COORD_MAX, COORD_MAX, 11'd0);
        send_command(OP_REMOVE, '0, '0, 11'd2);
        send_command(OP_QUERY,  COORD_MIN, COORD_MIN, 11'd0);
        send_command(OP_REMOVE, '0, '0, 11'd3);
        send_command(OP_REMOVE, '0, '0, 11'd2047);
        send_command(OP_INSERT, '0, '0, 11'd0);
        send_command(OP_INSERT, -32'sd1, 32'sd1, 11'd0);
        send_command(OP_INSERT, COORD_MAX, COORD_MIN, 11'd0);
        send_command(OP_QUERY,  COORD_MIN, COORD_MAX, 11'd0);
        send_command(OP_NONE,   -32'sd1, -32'sd1, 11'd2047);
        send_command(OP_REMOVE, '0, '0, 11'd1024);

        // random traffic: no idling, heavy idling, light idling
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            idle_pct = (k < RANDOM_ITEMS / 3) ? 0 : (k < 2 * RANDOM_ITEMS / 3) ? 86 : 8;
            send_random_item();
        end

        // closing items at the extremes
        idle_pct = 86;
        send_command(OP_INSERT, COORD_MAX, COORD_MAX, 11'd0);
        send_command(OP_QUERY,  COORD_MIN, COORD_MIN, 11'd0);
        send_command(OP_REMOVE, '0, '0, 11'd1024);
        send_command(OP_REMOVE, '0, '0, 11'd1024);
        send_command(OP_QUERY,  pick_coord(), pick_coord(), 11'd0);
        idle_pct = 8;
        send_command(OP_INSERT, COORD_MIN, COORD_MAX, 11'd1024);
        send_command(OP_REMOVE, '0, '0, 11'd0);
        send_command(OP_QUERY,  COORD_MAX, COORD_MIN, 11'd0);
        @(negedge i_clk);
        start <= 1'b0;

        // drain outstanding answers, then watch for stray results
        waited = 0;
        while (open_answers != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (MAX_POINTS + 8) @(negedge i_clk);
        if (open_answers != 0)
            $display("%0d items never answered", open_answers);

        if (fail_count == 0 && open_answers == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
